/* design/pvca_pkg.sv */
// Shared types and constants of the priority voice channel allocator.
package pvca_pkg;

  // Default table depth and configuration register layout
  localparam int MAX_CH_DEF = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

  // Stream payload widths
  localparam int IN_DATA_W = 40;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 16;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_STOP    = 2'd1,
    FN_RELEASE = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  // Result codes
  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_REUSED   = 3'd1,
    ST_PREEMPT  = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_STOPPED  = 3'd4,
    ST_NOMATCH  = 3'd5,
    ST_RELEASED = 3'd6
  } status_t;

  // One table entry (busy marks live in flops beside the table)
  typedef struct packed {
    logic [15:0] origin;
    logic [7:0]  sound;
    logic [7:0]  prio;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* design/pvca_ctrl.sv */
// Sequencing state machine of the priority voice channel allocator.
module pvca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pvca_pkg::sts_t   sts,
  output pvca_pkg::cmd_t   cmd
);

  pvca_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvca_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pvca_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = pvca_pkg::S_SCAN;
      end
      pvca_pkg::S_SCAN: begin
        if (sts.scan_done) state_nxt = pvca_pkg::S_DONE;
      end
      pvca_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = pvca_pkg::S_IDLE;
      end
      default: state_nxt = pvca_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      pvca_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      pvca_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      pvca_pkg::S_DONE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

/* design/pvca_dp.sv */
// Datapath: channel table, scan pipeline, result selection and output register.
module pvca_dp #(
  parameter int MAX_CHANNELS = pvca_pkg::MAX_CH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pvca_pkg::cmd_t                   cmd,
  output pvca_pkg::sts_t                   sts,
  input  logic [pvca_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [pvca_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pvca_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pvca_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  // Configuration
  logic [pvca_pkg::CFG_W-1:0] cfg_r;

  // Request latched at transfer
  pvca_pkg::func_t  func_r;
  pvca_pkg::entry_t req_r;
  logic [IW-1:0]    idx_r;
  logic [CW-1:0]    n_r;

  // Scan pipeline
  logic [CW-1:0]    rd_cnt_r;
  logic             chk_vld_r;
  logic [IW-1:0]    chk_idx_r;
  pvca_pkg::entry_t rdata_r;

  // Match and preemption candidates
  logic               hit_r;
  pvca_pkg::status_t  hit_status_r;
  logic [IW-1:0]      hit_chan_r;
  logic               hit_disp_r;
  logic [7:0]         hit_snd_r;
  logic               pre_found_r;
  logic [IW-1:0]      pre_idx_r;
  logic [7:0]         pre_snd_r;

  // Table
  logic [MAX_CHANNELS-1:0] busy_r;
  pvca_pkg::entry_t        mem [MAX_CHANNELS];

  // Output register
  logic                       out_tvalid_r;
  logic [pvca_pkg::OUT_DATA_W-1:0] out_data_r;

  // Decode of the incoming transfer
  pvca_pkg::func_t  in_func;
  pvca_pkg::entry_t in_entry;
  logic [7:0]       in_idx8;
  logic [7:0]       max8;
  logic [7:0]       cfg8;
  logic [CW-1:0]    n_cfg;
  logic             rel_ok;
  logic [CW-1:0]    n_load;

  assign in_func         = pvca_pkg::func_t'(in_tuser);
  assign in_entry.origin = in_tdata[15:0];
  assign in_entry.sound  = in_tdata[23:16];
  assign in_entry.prio   = in_tdata[31:24];
  assign in_idx8         = {4'b0000, in_tdata[35:32]};
  assign max8            = 8'(MAX_CHANNELS);
  assign cfg8            = 8'(cfg_r);
  assign n_cfg           = CW'((cfg8 > max8) ? max8 : cfg8);
  assign rel_ok          = (in_idx8 < max8);

  // Entries to check for this request
  always_comb begin
    unique case (in_func)
      pvca_pkg::FN_START:   n_load = n_cfg;
      pvca_pkg::FN_STOP:    n_load = n_cfg;
      pvca_pkg::FN_RELEASE: n_load = rel_ok ? CW'(1) : '0;
      pvca_pkg::FN_NONE:    n_load = '0;
      default:              n_load = '0;
    endcase
  end

  // Check stage: evaluate the entry read in the previous cycle
  logic              chk_on;
  logic              busy_c;
  logic              hit_now;
  pvca_pkg::status_t hit_status_now;
  logic              hit_disp_now;
  logic              pre_now;

  assign chk_on = cmd.scan && chk_vld_r && !hit_r;
  assign busy_c = busy_r[chk_idx_r];

  always_comb begin
    hit_now        = 1'b0;
    hit_status_now = pvca_pkg::ST_NOMATCH;
    hit_disp_now   = 1'b0;
    pre_now        = 1'b0;
    if (chk_on) begin
      unique case (func_r)
        pvca_pkg::FN_START: begin
          priority if (!busy_c) begin
            hit_now        = 1'b1;
            hit_status_now = pvca_pkg::ST_FREE;
          end else if (req_r.origin != '0 && rdata_r.origin == req_r.origin) begin
            hit_now        = 1'b1;
            hit_status_now = pvca_pkg::ST_REUSED;
            hit_disp_now   = 1'b1;
          end else begin
            pre_now = !pre_found_r && (rdata_r.prio >= req_r.prio);
          end
        end
        pvca_pkg::FN_STOP: begin
          if (busy_c && rdata_r.origin == req_r.origin) begin
            hit_now        = 1'b1;
            hit_status_now = pvca_pkg::ST_STOPPED;
            hit_disp_now   = 1'b1;
          end
        end
        pvca_pkg::FN_RELEASE: begin
          hit_now        = 1'b1;
          hit_status_now = pvca_pkg::ST_RELEASED;
          hit_disp_now   = busy_c;
        end
        pvca_pkg::FN_NONE: begin
          hit_now = 1'b0;
        end
        default: begin
          hit_now = 1'b0;
        end
      endcase
    end
  end

  // Read stage: next table address
  logic          issue;
  logic [IW-1:0] rd_addr;

  assign issue   = cmd.scan && !hit_r && !hit_now && (rd_cnt_r < n_r);
  assign rd_addr = (func_r == pvca_pkg::FN_RELEASE) ? idx_r : rd_cnt_r[IW-1:0];

  assign sts.scan_done = hit_r || (rd_cnt_r >= n_r && !chk_vld_r);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  // Final result of the request
  pvca_pkg::status_t fin_status;
  logic [IW-1:0]     fin_chan;
  logic              fin_disp;
  logic [7:0]        fin_snd;
  logic [7:0]        fin_chan8;

  always_comb begin
    priority if (hit_r) begin
      fin_status = hit_status_r;
      fin_chan   = hit_chan_r;
      fin_disp   = hit_disp_r;
      fin_snd    = hit_snd_r;
    end else if (func_r == pvca_pkg::FN_START && pre_found_r) begin
      fin_status = pvca_pkg::ST_PREEMPT;
      fin_chan   = pre_idx_r;
      fin_disp   = 1'b1;
      fin_snd    = pre_snd_r;
    end else if (func_r == pvca_pkg::FN_START) begin
      fin_status = pvca_pkg::ST_REFUSED;
      fin_chan   = '0;
      fin_disp   = 1'b0;
      fin_snd    = '0;
    end else begin
      fin_status = pvca_pkg::ST_NOMATCH;
      fin_chan   = '0;
      fin_disp   = 1'b0;
      fin_snd    = '0;
    end
  end

  assign fin_chan8 = 8'(fin_chan);

  // Table writeback
  logic assign_ok;
  logic free_ok;

  assign assign_ok = cmd.commit && (fin_status == pvca_pkg::ST_FREE ||
                                    fin_status == pvca_pkg::ST_REUSED ||
                                    fin_status == pvca_pkg::ST_PREEMPT);
  assign free_ok   = cmd.commit && fin_disp && (fin_status == pvca_pkg::ST_STOPPED ||
                                                fin_status == pvca_pkg::ST_RELEASED);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= pvca_pkg::CFG_RESET;
      rd_cnt_r     <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      pre_found_r  <= 1'b0;
      busy_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) cfg_r <= cfg_data;
      if (cmd.load) begin
        rd_cnt_r    <= '0;
        chk_vld_r   <= 1'b0;
        hit_r       <= 1'b0;
        pre_found_r <= 1'b0;
      end else if (cmd.scan) begin
        if (issue) rd_cnt_r <= rd_cnt_r + CW'(1);
        chk_vld_r <= issue;
        if (hit_now) hit_r <= 1'b1;
        if (pre_now) pre_found_r <= 1'b1;
      end
      if (assign_ok) busy_r[fin_chan] <= 1'b1;
      else if (free_ok) busy_r[fin_chan] <= 1'b0;
      if (cmd.commit) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      req_r  <= in_entry;
      idx_r  <= IW'(in_idx8);
      n_r    <= n_load;
    end
    if (cmd.scan) chk_idx_r <= rd_addr;
    if (hit_now) begin
      hit_status_r <= hit_status_now;
      hit_chan_r   <= chk_idx_r;
      hit_disp_r   <= hit_disp_now;
      hit_snd_r    <= rdata_r.sound;
    end
    if (pre_now) begin
      pre_idx_r <= chk_idx_r;
      pre_snd_r <= rdata_r.sound;
    end
    if (cmd.commit) begin
      out_data_r <= {fin_disp, (fin_disp ? fin_snd : 8'h00), fin_chan8[3:0], fin_status};
    end
  end

  // Channel table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (assign_ok) mem[fin_chan] <= req_r;
    if (issue) rdata_r <= mem[rd_addr];
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // A displaced sound always comes from a channel that is still marked busy
  a_disp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && fin_disp |-> busy_r[fin_chan])
    else $error("displaced sound from an idle channel");

  // A free-channel hit points at a channel that is idle when the hit is registered
  a_free_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hit_r) && func_r == pvca_pkg::FN_START && hit_status_r == pvca_pkg::ST_FREE
    |-> !busy_r[hit_chan_r])
    else $error("free hit on a busy channel");

  // Every commit leaves a result waiting on the output
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid_r)
    else $error("committed result not presented");

  // During a scan the read counter never passes the channel count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> rd_cnt_r <= n_r)
    else $error("scan ran past channel count");

endmodule

/* design/priority_voice_channel_allocator.sv */
// Top level of the priority voice channel allocator.
//
// Requests enter on the in_ stream: in_tuser carries the request kind (start,
// stop by origin, release by index), in_tdata the origin, sound, priority and
// channel index. Every request yields exactly one result on the out_ stream:
// status, channel, displaced sound and its valid flag.
// The cfg_ channel writes channels_in_use, the number of table entries a start
// or stop scans; it is always ready and should be written only while idle.
// One request is handled at a time; a start or stop reads one table entry per
// cycle through the table's single read port. A start or stop scans the channels
// in use from channel 0, and a match ends the scan early. A release reads only
// the indexed entry, if it lies within the table; an unused kind, or a start or
// stop with no channels in use, reads no entry.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, the following request completes its scan and then
// holds until the previous result has been transferred.
// Reset (rst_n low at a clock edge) marks every channel idle and sets
// channels_in_use to 8. Table contents need no clearing.
module priority_voice_channel_allocator #(
  parameter int MAX_CHANNELS = pvca_pkg::MAX_CH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: origin_id[15:0], sound_id[23:16], sound_priority[31:24],
  //           channel_index[35:32], zero[39:36]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pvca_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func[1:0]
  input  logic [pvca_pkg::IN_USER_W-1:0]  in_tuser,
  // out_tdata: status[2:0], channel[6:3], displaced_sound[14:7],
  //            displaced_valid[15]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pvca_pkg::OUT_DATA_W-1:0] out_tdata,
  // cfg_data: channels_in_use[4:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pvca_pkg::CFG_W-1:0]      cfg_data
);

  pvca_pkg::cmd_t cmd;
  pvca_pkg::sts_t sts;

  pvca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pvca_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
